FILE: src/ltr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltr_pkg: shared types and constants for the longest equal run tracker
// Holds the tree geometry, the packed tree node and the result saturation.
// ----------------------------------------------------------------------------
package ltr_pkg;

   // Tree geometry. The string length is a power of two, so the leaf for a
   // position sits at slot LENGTH_MAX + position and the root at slot 1.
   localparam int LENGTH_MAX = 1024;
   localparam int SLOT_COUNT = 2 * LENGTH_MAX;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int RUN_W      = $clog2(LENGTH_MAX + 1);

   // Beat field widths.
   localparam int POS_W    = 10;
   localparam int SYM_W    = 8;
   localparam int RESULT_W = 11;
   localparam int RESULT_MAX = 2047;

   // Request mode codes.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   // Slot numbers that the walk refers to by name.
   localparam logic [SLOT_W-1:0] ROOT_SLOT = SLOT_W'(1);

   // One tree node as it is kept in the node memory.
   typedef struct packed {
      logic [RUN_W-1:0] size;
      logic [SYM_W-1:0] first_sym;
      logic [SYM_W-1:0] last_sym;
      logic [RUN_W-1:0] prefix;
      logic [RUN_W-1:0] suffix;
      logic [RUN_W-1:0] longest;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // Clamp a run length to the width of the result field.
   function automatic logic [RESULT_W-1:0] sat_result(input logic [RUN_W-1:0] run);
      logic [31:0] wide;
      wide = 32'(run);
      if (wide > 32'(RESULT_MAX)) begin
         return RESULT_W'(RESULT_MAX);
      end
      return RESULT_W'(wide);
   endfunction

endpackage
`default_nettype wire

FILE: src/longest_equal_run_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_equal_run_tracker_core: segment tree tracker of the longest run
// Writes one symbol per request beat into a leaf of a node memory and walks
// to the root, merging one tree level per cycle through a shared merge unit.
// A new beat is taken only in the idle state, after the walk of the previous
// beat is through and, for an update, after its response is registered; the
// walk does one sibling read from the node memory per tree level (10 levels).
// Reset: synchronous; afterwards a clearing pass writes all 2048 node slots
// to empty, during which req_stall stays high.
// ----------------------------------------------------------------------------
module longest_equal_run_tracker_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_mode,
   input  wire logic [ltr_pkg::POS_W-1:0]     req_position,
   input  wire logic [ltr_pkg::SYM_W-1:0]     req_symbol,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [ltr_pkg::RESULT_W-1:0]  rsp_longest_run
);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LEAF  = 3'd2;
   localparam logic [2:0] ST_MERGE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [ltr_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic [ltr_pkg::SLOT_W-1:0]         clr_ff, clr_in;
   ltr_pkg::node_type                  cur_ff, cur_in;
   logic                               mode_ff, mode_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ltr_pkg::RESULT_W-1:0]       rsp_longest_run_ff, rsp_longest_run_in;

   logic                               req_take;
   logic                               out_free;
   logic [ltr_pkg::SLOT_W-1:0]         parent;
   ltr_pkg::node_type                  leaf_node;
   ltr_pkg::node_type                  lo_node, hi_node, joined;

   logic                               wr_en;
   logic [ltr_pkg::SLOT_W-1:0]         wr_addr;
   ltr_pkg::node_type                  wr_data;
   logic                               rd_en;
   logic [ltr_pkg::SLOT_W-1:0]         rd_addr;
   logic [ltr_pkg::NODE_W-1:0]         rd_data;

   // Node memory: one slot per tree node, root at slot 1.
   ltr_ram #(
      .WIDTH(ltr_pkg::NODE_W),
      .DEPTH(ltr_pkg::SLOT_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // The node on the walk is the left child when its slot is even.
   assign lo_node = slot_ff[0] ? ltr_pkg::node_type'(rd_data) : cur_ff;
   assign hi_node = slot_ff[0] ? cur_ff : ltr_pkg::node_type'(rd_data);

   ltr_join u_join (
      .lo    (lo_node),
      .hi    (hi_node),
      .joined(joined)
   );

   assign parent   = slot_ff >> 1;
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A freshly written leaf is a run of one.
   always_comb begin
      leaf_node.size      = ltr_pkg::RUN_W'(1);
      leaf_node.first_sym = req_symbol;
      leaf_node.last_sym  = req_symbol;
      leaf_node.prefix    = ltr_pkg::RUN_W'(1);
      leaf_node.suffix    = ltr_pkg::RUN_W'(1);
      leaf_node.longest   = ltr_pkg::RUN_W'(1);
   end

   // Sequencer: clearing pass, leaf write, one merge per level, response on updates.
   always_comb begin
      state_in           = state_ff;
      slot_in            = slot_ff;
      clr_in             = clr_ff;
      cur_in             = cur_ff;
      mode_in            = mode_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_longest_run_in = rsp_longest_run_ff;
      wr_en              = 1'b0;
      wr_addr            = slot_ff;
      wr_data            = cur_ff;
      rd_en              = 1'b0;
      rd_addr            = slot_ff ^ ltr_pkg::SLOT_W'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ltr_pkg::SLOT_W'(1);
            if (clr_ff == ltr_pkg::SLOT_W'(ltr_pkg::SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               slot_in  = ltr_pkg::SLOT_W'(ltr_pkg::LENGTH_MAX)
                        + ltr_pkg::SLOT_W'(req_position);
               cur_in   = leaf_node;
               mode_in  = req_mode;
               state_in = ST_LEAF;
            end
         end
         ST_LEAF: begin
            // Write the leaf and fetch its sibling.
            wr_en    = 1'b1;
            rd_en    = 1'b1;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            // Write the merged parent and fetch the parent's sibling.
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = joined;
            rd_en   = 1'b1;
            rd_addr = parent ^ ltr_pkg::SLOT_W'(1);
            cur_in  = joined;
            slot_in = parent;
            if (parent == ltr_pkg::ROOT_SLOT) begin
               state_in = (mode_ff == ltr_pkg::MODE_UPDATE) ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_longest_run_in = ltr_pkg::sat_result(cur_ff.longest);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff            <= slot_in;
      cur_ff             <= cur_in;
      mode_ff            <= mode_in;
      rsp_longest_run_ff <= rsp_longest_run_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_longest_run_ff;

endmodule
`default_nettype wire

FILE: src/ltr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ltr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/ltr_join.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltr_join: node merge unit
// Combines a left and a right child node into their parent node.
// ----------------------------------------------------------------------------
module ltr_join (
   input  wire ltr_pkg::node_type lo,
   input  wire ltr_pkg::node_type hi,
   output      ltr_pkg::node_type joined
);

   logic [ltr_pkg::RUN_W-1:0] best_side;
   logic [ltr_pkg::RUN_W-1:0] bridge;

   // Longest run of either child, and the run that spans the split.
   assign best_side = (lo.longest > hi.longest) ? lo.longest : hi.longest;
   assign bridge    = lo.suffix + hi.prefix;

   always_comb begin
      if (lo.size == '0) begin
         // An empty left child passes the right one through.
         joined = hi;
      end else if (hi.size == '0) begin
         joined = lo;
      end else begin
         joined.size      = lo.size + hi.size;
         joined.first_sym = lo.first_sym;
         joined.last_sym  = hi.last_sym;
         // The prefix grows into the right child when the left is one run of the right's first symbol.
         joined.prefix = lo.prefix;
         if (lo.prefix == lo.size && lo.first_sym == hi.first_sym) begin
            joined.prefix = lo.prefix + hi.prefix;
         end
         // The suffix grows into the left child when the right is one run of the left's last symbol.
         joined.suffix = hi.suffix;
         if (hi.suffix == hi.size && lo.last_sym == hi.last_sym) begin
            joined.suffix = hi.suffix + lo.suffix;
         end
         joined.longest = best_side;
         if (lo.last_sym == hi.first_sym && bridge > best_side) begin
            joined.longest = bridge;
         end
      end
   end

endmodule
`default_nettype wire
